>>> rtl/core/websocket_text_message_deframer_macros.svh
// Assertion helpers shared by the deframer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef WEBSOCKET_TEXT_MESSAGE_DEFRAMER_MACROS_SVH
`define WEBSOCKET_TEXT_MESSAGE_DEFRAMER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_MSG    = 3'd0;
  localparam logic [2:0] KIND_PING   = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_CLOSED = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Error codes reported with an error result.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_RESERVED   = 3'd1;
  localparam logic [2:0] ERR_FRAME_BIG  = 3'd2;
  localparam logic [2:0] ERR_MSG_BIG    = 3'd3;
  localparam logic [2:0] ERR_BAD_CTRL   = 3'd4;
  localparam logic [2:0] ERR_UNEXP_TEXT = 3'd5;
  localparam logic [2:0] ERR_UNEXP_CONT = 3'd6;
  localparam logic [2:0] ERR_UNKNOWN_OP = 3'd7;

  // Reset value of the size limit register.
  localparam logic [31:0] MAX_BYTES_RESET = 32'd1048576;

  // One result transaction.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] error_code;
  } wsd_result_t;

endpackage

>>> rtl/core/wsd_parser.sv
`timescale 1ns / 1ps
`include "websocket_text_message_deframer_macros.svh"

module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_acc,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] max_bytes,
  output logic        res_valid,
  output wsd_result_t res
);

  // Parse phases.
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  logic [2:0]  phase_r,     phase_nxt;
  logic [3:0]  hcount_r,    hcount_nxt;
  logic [63:0] flen_r,      flen_nxt;
  logic [31:0] brem_r,      brem_nxt;
  logic [31:0] mkey_r,      mkey_nxt;
  logic [1:0]  midx_r,      midx_nxt;
  logic        masked_r,    masked_nxt;
  logic        fin_r,       fin_nxt;
  logic [3:0]  opcode_r,    opcode_nxt;
  logic        started_r,   started_nxt;
  logic [31:0] msg_bytes_r, msg_bytes_nxt;
  logic        stopped_r,   stopped_nxt;

  logic [63:0] flen_shift;
  logic [3:0]  hc_dec;
  logic [63:0] hd_len;
  logic [32:0] msg_sum;
  logic        too_big;
  logic        msg_over;
  logic        len_zero;
  logic        len_gt125;
  logic        is_data_op;
  logic        do_hd;
  logic [7:0]  key_byte;
  logic [7:0]  pay_byte;
  logic [31:0] brem_dec;
  logic        final_byte;

  // Shared header arithmetic: the length seen when the header completes.
  always_comb begin
    flen_shift = {flen_r[55:0], rx_byte};
    hc_dec     = hcount_r - 4'd1;
    case (phase_r)
      PH_SECOND: hd_len = {57'd0, rx_byte[6:0]};
      PH_EXTLEN: hd_len = flen_shift;
      default:   hd_len = flen_r;
    endcase
    too_big    = (hd_len[63:32] != 32'd0) || (hd_len[31:0] > max_bytes);
    msg_sum    = {1'b0, msg_bytes_r} + {1'b0, hd_len[31:0]};
    msg_over   = msg_sum > {1'b0, max_bytes};
    len_zero   = (hd_len == 64'd0);
    len_gt125  = (hd_len[31:0] > 32'd125);
    is_data_op = (opcode_r == OP_CONT) || (opcode_r == OP_TEXT);
  end

  // Payload unmasking and length countdown.
  always_comb begin
    case (midx_r)
      2'd0:    key_byte = mkey_r[31:24];
      2'd1:    key_byte = mkey_r[23:16];
      2'd2:    key_byte = mkey_r[15:8];
      default: key_byte = mkey_r[7:0];
    endcase
    pay_byte   = masked_r ? (rx_byte ^ key_byte) : rx_byte;
    brem_dec   = brem_r - 32'd1;
    final_byte = (brem_dec == 32'd0);
  end

  // Next state and result for the accepted byte.
  always_comb begin
    phase_nxt     = phase_r;
    hcount_nxt    = hcount_r;
    flen_nxt      = flen_r;
    brem_nxt      = brem_r;
    mkey_nxt      = mkey_r;
    midx_nxt      = midx_r;
    masked_nxt    = masked_r;
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    started_nxt   = started_r;
    msg_bytes_nxt = msg_bytes_r;
    stopped_nxt   = stopped_r;
    do_hd         = 1'b0;
    res_valid     = 1'b0;
    res           = '{kind: KIND_MSG, data_byte: 8'd0, last: 1'b0, error_code: ERR_NONE};

    if (byte_acc && !stopped_r) begin
      unique case (phase_r)
        PH_FIRST: begin
          fin_nxt    = rx_byte[7];
          opcode_nxt = rx_byte[3:0];
          if (rx_byte[6:4] != 3'd0) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_ERROR;
            res.error_code = ERR_RESERVED;
          end else begin
            phase_nxt = PH_SECOND;
          end
        end
        PH_SECOND: begin
          masked_nxt = rx_byte[7];
          if (rx_byte[6:1] == 6'b111111) begin
            // Extended length follows: two bytes for 126, eight for 127.
            hcount_nxt = rx_byte[0] ? 4'd8 : 4'd2;
            flen_nxt   = 64'd0;
            phase_nxt  = PH_EXTLEN;
          end else begin
            flen_nxt = hd_len;
            if (rx_byte[7]) begin
              hcount_nxt = 4'd4;
              mkey_nxt   = 32'd0;
              phase_nxt  = PH_MASK;
            end else begin
              do_hd = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          flen_nxt   = flen_shift;
          hcount_nxt = hc_dec;
          if (hc_dec == 4'd0) begin
            if (masked_r) begin
              hcount_nxt = 4'd4;
              mkey_nxt   = 32'd0;
              phase_nxt  = PH_MASK;
            end else begin
              do_hd = 1'b1;
            end
          end
        end
        PH_MASK: begin
          mkey_nxt   = {mkey_r[23:0], rx_byte};
          hcount_nxt = hc_dec;
          if (hc_dec == 4'd0) begin
            do_hd = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          midx_nxt = midx_r + 2'd1;
          brem_nxt = brem_dec;
          if (final_byte) begin
            phase_nxt = PH_FIRST;
          end
          if (is_data_op) begin
            res_valid      = 1'b1;
            res.kind       = KIND_MSG;
            res.data_byte  = pay_byte;
            res.last       = final_byte && fin_r;
            if (final_byte && fin_r) begin
              started_nxt   = 1'b0;
              msg_bytes_nxt = 32'd0;
            end
          end else if (opcode_r == OP_PING) begin
            res_valid     = 1'b1;
            res.kind      = KIND_PING;
            res.data_byte = pay_byte;
            res.last      = final_byte;
          end else if ((opcode_r == OP_CLOSE) && final_byte) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = KIND_CLOSED;
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase

      // Header complete: run the checks in priority order, then set up the payload or finish a zero-length frame.
      if (do_hd) begin
        if (too_big || msg_over ||
            (((opcode_r == OP_PING) || (opcode_r == OP_PONG)) && (!fin_r || len_gt125)) ||
            ((opcode_r == OP_TEXT) && started_r) ||
            ((opcode_r == OP_CONT) && !started_r) ||
            (!is_data_op && (opcode_r != OP_CLOSE) && (opcode_r != OP_PING) &&
             (opcode_r != OP_PONG))) begin
          stopped_nxt = 1'b1;
          res_valid   = 1'b1;
          res.kind    = KIND_ERROR;
          if (too_big) begin
            res.error_code = ERR_FRAME_BIG;
          end else if (msg_over) begin
            res.error_code = ERR_MSG_BIG;
          end else if ((opcode_r == OP_PING) || (opcode_r == OP_PONG)) begin
            res.error_code = ERR_BAD_CTRL;
          end else if (opcode_r == OP_TEXT) begin
            res.error_code = ERR_UNEXP_TEXT;
          end else if (opcode_r == OP_CONT) begin
            res.error_code = ERR_UNEXP_CONT;
          end else begin
            res.error_code = ERR_UNKNOWN_OP;
          end
        end else begin
          if (opcode_r == OP_TEXT) begin
            started_nxt = 1'b1;
          end
          if (is_data_op) begin
            msg_bytes_nxt = msg_sum[31:0];
          end
          midx_nxt  = 2'd0;
          phase_nxt = PH_FIRST;
          if (len_zero) begin
            if (opcode_r == OP_CLOSE) begin
              stopped_nxt = 1'b1;
              res_valid   = 1'b1;
              res.kind    = KIND_CLOSED;
            end else if (is_data_op && fin_r) begin
              started_nxt   = 1'b0;
              msg_bytes_nxt = 32'd0;
              res_valid     = 1'b1;
              res.kind      = KIND_EMPTY;
              res.last      = 1'b1;
            end
          end else begin
            brem_nxt  = hd_len[31:0];
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      hcount_r    <= 4'd0;
      flen_r      <= 64'd0;
      brem_r      <= 32'd0;
      mkey_r      <= 32'd0;
      midx_r      <= 2'd0;
      masked_r    <= 1'b0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      started_r   <= 1'b0;
      msg_bytes_r <= 32'd0;
      stopped_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hcount_r    <= hcount_nxt;
      flen_r      <= flen_nxt;
      brem_r      <= brem_nxt;
      mkey_r      <= mkey_nxt;
      midx_r      <= midx_nxt;
      masked_r    <= masked_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      started_r   <= started_nxt;
      msg_bytes_r <= msg_bytes_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  `WSD_ASSERT_NEXT(a_stop_sticky, stopped_r, stopped_r, "stopped flag cleared without reset")
  `WSD_ASSERT_NOW(a_no_res_stopped, stopped_r, !res_valid, "result produced while stopped")
  `WSD_ASSERT_NOW(a_err_code, res_valid, ((res.kind == KIND_ERROR) == (res.error_code != ERR_NONE)), "error code does not match kind")

endmodule

>>> rtl/core/wsd_out_buf.sv
`timescale 1ns / 1ps
`include "websocket_text_message_deframer_macros.svh"

module wsd_out_buf
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  wsd_result_t push_res,
  output logic        has_room,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_result_t out_res
);

  // Two-entry result queue so input can keep flowing while a result waits.
  wsd_result_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r,  count_nxt;
  logic        pop;

  assign has_room  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  `WSD_ASSERT_NOW(a_no_overflow, push, (count_r != 2'd2), "result pushed into a full queue")
  `WSD_ASSERT_NOW(a_count_range, 1'b1, (count_r != 2'd3), "queue count out of range")
  `WSD_ASSERT_NEXT(a_full_held, ((count_r == 2'd2) && !out_ready), (count_r == 2'd2), "full queue drained without a pop")

endmodule

>>> rtl/core/websocket_text_message_deframer.sv
`timescale 1ns / 1ps
// Channel | Direction | Ports                                         | Transfer
// in      | input     | in_valid, in_ready, in_rx_byte                | one received byte
// out     | output    | out_valid, out_ready, out_kind, out_data_byte,| zero or one result
//         |           | out_last, out_error_code                      | per input byte
// cfg     | input     | cfg_valid, cfg_ready, cfg_data                | max_message_bytes write
//
// Each byte is parsed in the cycle it is accepted; its result, if any, is registered into the result queue.
// One byte per cycle is sustained while out_ready is high; the parser state update sets this.
// A two-entry result queue lets input continue while one result waits; in_ready drops when full.
// Synchronous active-low reset clears the parser and sets the limit to 1048576.
// After an error or close result the block accepts bytes but produces nothing until reset.
module websocket_text_message_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] max_bytes_r, max_bytes_nxt;
  logic        byte_acc;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;
  logic        has_room;

  // Size limit register, always writable.
  assign cfg_ready     = 1'b1;
  assign max_bytes_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RESET;
    end else begin
      max_bytes_r <= max_bytes_nxt;
    end
  end

  assign in_ready = has_room;
  assign byte_acc = in_valid && in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .max_bytes (max_bytes_r),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_data_byte  = out_res.data_byte;
  assign out_last       = out_res.last;
  assign out_error_code = out_res.error_code;

endmodule

>>> tb/sv/tb_websocket_text_message_deframer.sv
`timescale 1ns / 1ps

module tb_websocket_text_message_deframer;
  import wsd_pkg::*;

  // Frame opcodes used by the stimulus and the predictor.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'ha;

  // Length encodings of the second header byte.
  localparam int FORM_SHORT = 0;
  localparam int FORM_16    = 1;
  localparam int FORM_64    = 2;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 40;

  typedef enum logic [2:0] {
    PH_FIRST, PH_SECOND, PH_EXTLEN, PH_MASK, PH_PAYLOAD
  } parse_phase_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic [2:0]  out_error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  websocket_text_message_deframer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_error_code (out_error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Predictor state of the deframer.
  parse_phase_e phase      = PH_FIRST;
  logic [3:0]   ext_left   = '0;
  logic [63:0]  frame_len  = '0;
  logic [31:0]  remaining  = '0;
  logic [31:0]  mask_word  = '0;
  logic [1:0]   mask_pos   = '0;
  bit           masked     = 1'b0;
  bit           fin_flag   = 1'b0;
  logic [3:0]   opcode     = '0;
  bit           msg_open   = 1'b0;
  logic [31:0]  msg_count  = '0;
  bit           halted     = 1'b0;
  logic [31:0]  limit_bytes = MAX_BYTES_RESET;

  wsd_result_t pending_results[$];

  int    bytes_sent     = 0;
  int    results_seen   = 0;
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  int    send_idle_pct  = 0;
  int    recv_idle_pct  = 0;
  bit    hold_on        = 1'b0;
  int    hold_count     = 0;
  string ending_name    = "none";

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run limit of %0d cycles reached, %0d results pending",
               LIMIT_CYCLES, pending_results.size());
      $display("websocket_text_message_deframer: mismatch");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_on && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_on) hold_count <= 0;
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest expected result.
  always @(posedge clk) begin
    wsd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", out_kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) flag_mismatch("kind", out_kind, want.kind);
        if (out_data_byte !== want.data_byte)
          flag_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_last !== want.last) flag_mismatch("last", out_last, want.last);
        if (out_error_code !== want.error_code)
          flag_mismatch("error_code", out_error_code, want.error_code);
      end
    end
  end

  task automatic queue_result(input logic [2:0] kind, input logic [7:0] data,
                              input logic last, input logic [2:0] code);
    wsd_result_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.last       = last;
    r.error_code = code;
    pending_results.push_back(r);
  endtask

  task automatic halt_with(input logic [2:0] code);
    halted = 1'b1;
    queue_result(KIND_ERROR, 8'h00, 1'b0, code);
  endtask

  // Header complete: run the size and opcode checks, then set up the payload or finish a zero-length frame.
  task automatic finish_header();
    bit is_msg;
    is_msg = (opcode == OP_CONT) || (opcode == OP_TEXT);
    if (frame_len > {32'd0, limit_bytes}) begin
      halt_with(ERR_FRAME_BIG);
      return;
    end
    if ({32'd0, msg_count} + frame_len > {32'd0, limit_bytes}) begin
      halt_with(ERR_MSG_BIG);
      return;
    end
    if (opcode == OP_PING || opcode == OP_PONG) begin
      if (!fin_flag || frame_len > 64'd125) begin
        halt_with(ERR_BAD_CTRL);
        return;
      end
    end else if (opcode == OP_TEXT) begin
      if (msg_open) begin
        halt_with(ERR_UNEXP_TEXT);
        return;
      end
      msg_open = 1'b1;
    end else if (opcode == OP_CONT) begin
      if (!msg_open) begin
        halt_with(ERR_UNEXP_CONT);
        return;
      end
    end else if (opcode != OP_CLOSE) begin
      halt_with(ERR_UNKNOWN_OP);
      return;
    end
    if (is_msg) msg_count = msg_count + frame_len[31:0];
    mask_pos = '0;
    phase    = PH_FIRST;
    if (frame_len == 64'd0) begin
      if (opcode == OP_CLOSE) begin
        halted = 1'b1;
        queue_result(KIND_CLOSED, 8'h00, 1'b0, ERR_NONE);
      end else if (is_msg && fin_flag) begin
        msg_open  = 1'b0;
        msg_count = '0;
        queue_result(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
      end
      return;
    end
    remaining = frame_len[31:0];
    phase     = PH_PAYLOAD;
  endtask

  task automatic finish_length();
    if (masked) begin
      ext_left  = 4'd4;
      mask_word = '0;
      phase     = PH_MASK;
    end else begin
      finish_header();
    end
  endtask

  // Advance the predicted parser by one accepted byte.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] data;
    bit         final_byte;
    bit         ends;
    if (halted) return;
    case (phase)
      PH_FIRST: begin
        fin_flag = b[7];
        opcode   = b[3:0];
        if (b[6:4] != 3'd0) halt_with(ERR_RESERVED);
        else phase = PH_SECOND;
      end
      PH_SECOND: begin
        masked    = b[7];
        frame_len = {57'd0, b[6:0]};
        if (b[6:0] == 7'd126 || b[6:0] == 7'd127) begin
          ext_left  = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
          frame_len = '0;
          phase     = PH_EXTLEN;
        end else begin
          finish_length();
        end
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        ext_left  = ext_left - 4'd1;
        if (ext_left == 4'd0) finish_length();
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        ext_left  = ext_left - 4'd1;
        if (ext_left == 4'd0) finish_header();
      end
      PH_PAYLOAD: begin
        data = b;
        if (masked) data = data ^ mask_word[8 * (3 - mask_pos) +: 8];
        mask_pos   = mask_pos + 2'd1;
        remaining  = remaining - 32'd1;
        final_byte = (remaining == 32'd0);
        if (final_byte) phase = PH_FIRST;
        if (opcode == OP_CONT || opcode == OP_TEXT) begin
          ends = final_byte && fin_flag;
          if (ends) begin
            msg_open  = 1'b0;
            msg_count = '0;
          end
          queue_result(KIND_MSG, data, ends, ERR_NONE);
        end else if (opcode == OP_PING) begin
          queue_result(KIND_PING, data, final_byte, ERR_NONE);
        end else if (opcode == OP_CLOSE && final_byte) begin
          halted = 1'b1;
          queue_result(KIND_CLOSED, 8'h00, 1'b0, ERR_NONE);
        end
      end
      default: phase = PH_FIRST;
    endcase
  endtask

  // Offer one byte, with random gaps first, and predict it once accepted.
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Size limit write, only with the block idle.
  task automatic write_limit(input logic [31:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_bytes = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send a header, then body payload bytes (random when fill is negative).
  task automatic send_frame(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic [63:0] len, input int form, input bit with_mask,
                            input logic [31:0] key, input int body, input int fill);
    logic [6:0] code;
    code = (form == FORM_SHORT) ? len[6:0] : (form == FORM_16) ? 7'd126 : 7'd127;
    push_byte({fin, rsv, op});
    push_byte({with_mask, code});
    if (form == FORM_16) begin
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else if (form == FORM_64) begin
      for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
    end
    if (with_mask)
      for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
    for (int i = 0; i < body; i++) begin
      if (fill < 0) push_byte(8'($urandom));
      else push_byte(fill[7:0]);
    end
  endtask

  function automatic int pick_form(input int len);
    int r;
    r = $urandom_range(99);
    if (len > 125) return (r < 70) ? FORM_16 : FORM_64;
    if (r < 70) return FORM_SHORT;
    return (r < 90) ? FORM_16 : FORM_64;
  endfunction

  function automatic int random_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(16, 1);
    if (r < 95) return $urandom_range(125, 17);
    return $urandom_range(260, 126);
  endfunction

  // One well-formed frame that stays within the limit for the open message.
  task automatic send_random_frame();
    int          r;
    int          len;
    logic [3:0]  op;
    bit          fin;
    logic [31:0] room;
    room = limit_bytes - msg_count;
    r    = $urandom_range(99);
    len  = random_length();
    if (r < 65) begin
      op  = msg_open ? OP_CONT : OP_TEXT;
      fin = $urandom_range(1);
    end else begin
      op  = (r < 85) ? OP_PING : OP_PONG;
      fin = 1'b1;
      if (len > 125) len = $urandom_range(125);
    end
    if (longint'(len) > longint'(room)) len = int'(room);
    // A message that has used up the limit can only be closed by an empty final frame.
    if (op == OP_CONT && room == 32'd0) fin = 1'b1;
    send_frame(fin, 3'd0, op, len, pick_form(len), $urandom_range(99) < 75,
               $urandom, len, -1);
  endtask

  // Directed frames: length forms, masking, fragments, control frames and empty frames.
  task automatic test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 30;
    send_frame(1'b1, 3'd0, OP_TEXT, 3, FORM_SHORT, 1'b0, 32'd0, 3, -1);
    send_frame(1'b0, 3'd0, OP_TEXT, 2, FORM_16, 1'b1, 32'hffff_ffff, 2, 8'h00);
    send_frame(1'b1, 3'd0, OP_PING, 2, FORM_SHORT, 1'b1, 32'h0000_0000, 2, 8'hff);
    send_frame(1'b1, 3'd0, OP_PONG, 3, FORM_SHORT, 1'b1, $urandom, 3, -1);
    send_frame(1'b0, 3'd0, OP_CONT, 0, FORM_SHORT, 1'b0, 32'd0, 0, -1);
    send_frame(1'b1, 3'd0, OP_CONT, 2, FORM_64, 1'b1, $urandom, 2, -1);
    send_frame(1'b1, 3'd0, OP_PING, 0, FORM_SHORT, 1'b0, 32'd0, 0, -1);
    send_frame(1'b1, 3'd0, OP_TEXT, 0, FORM_SHORT, 1'b1, $urandom, 0, -1);
    wait_for_results();
  endtask

  // Size limit at zero, at a tight value, at its maximum and back at reset.
  task automatic test_limit_settings();
    write_limit(32'd0);
    send_frame(1'b1, 3'd0, OP_TEXT, 0, FORM_SHORT, 1'b0, 32'd0, 0, -1);
    send_frame(1'b1, 3'd0, OP_PONG, 0, FORM_16, 1'b1, $urandom, 0, -1);
    send_frame(1'b0, 3'd0, OP_TEXT, 0, FORM_SHORT, 1'b0, 32'd0, 0, -1);
    send_frame(1'b1, 3'd0, OP_CONT, 0, FORM_64, 1'b0, 32'd0, 0, -1);
    write_limit(32'd5);
    send_frame(1'b0, 3'd0, OP_TEXT, 3, FORM_SHORT, 1'b1, $urandom, 3, -1);
    send_frame(1'b1, 3'd0, OP_PING, 2, FORM_SHORT, 1'b1, $urandom, 2, -1);
    send_frame(1'b1, 3'd0, OP_CONT, 2, FORM_16, 1'b0, 32'd0, 2, -1);
    write_limit(32'hffff_ffff);
    send_frame(1'b1, 3'd0, OP_TEXT, 200, FORM_64, 1'b1, $urandom, 200, -1);
    write_limit(MAX_BYTES_RESET);
    send_frame(1'b1, 3'd0, OP_TEXT, 130, FORM_16, 1'b1, $urandom, 130, -1);
    wait_for_results();
  endtask

  // Random well-formed traffic under a random limit, ending with no message open.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int start;
    write_limit($urandom_range(700, 200));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_frame();
    if (msg_open)
      send_frame(1'b1, 3'd0, OP_CONT, 0, FORM_SHORT, 1'b1, $urandom, 0, -1);
    wait_for_results();
  endtask

  // Receiver holds off while a long ping payload is offered, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_on = 1'b1;
    send_frame(1'b1, 3'd0, OP_PING, 80, FORM_SHORT, 1'b1, $urandom, 80, -1);
    wait_for_results();
    hold_on = 1'b0;
  endtask

  // One stopping condition, chosen at random, followed by bytes that must be ignored.
  task automatic test_stop_condition();
    int         pick;
    logic [3:0] odd_op;
    write_limit(32'd200);
    send_idle_pct = 16;
    recv_idle_pct = 16;
    pick = $urandom_range(8);
    case (pick)
      0: begin
        ending_name = "close with payload";
        send_frame(1'b1, 3'd0, OP_CLOSE, 3, FORM_SHORT, 1'b1, $urandom, 3, -1);
      end
      1: begin
        ending_name = "empty close";
        send_frame(1'b1, 3'd0, OP_CLOSE, 0, FORM_SHORT, 1'b0, 32'd0, 0, -1);
      end
      2: begin
        ending_name = "reserved bits";
        push_byte({1'b1, 3'($urandom_range(7, 1)), OP_TEXT});
      end
      3: begin
        ending_name = "frame too large";
        send_frame(1'b1, 3'd0, OP_TEXT, 64'h0000_0001_0000_0000, FORM_64, 1'b0,
                   32'd0, 0, -1);
      end
      4: begin
        ending_name = "message too large";
        send_frame(1'b0, 3'd0, OP_TEXT, 120, FORM_SHORT, 1'b1, $urandom, 120, -1);
        send_frame(1'b1, 3'd0, OP_CONT, 100, FORM_SHORT, 1'b0, 32'd0, 0, -1);
      end
      5: begin
        ending_name = "bad control frame";
        if ($urandom_range(1))
          send_frame(1'b0, 3'd0, OP_PING, 1, FORM_SHORT, 1'b0, 32'd0, 0, -1);
        else
          send_frame(1'b1, 3'd0, OP_PONG, 126, FORM_16, 1'b1, $urandom, 0, -1);
      end
      6: begin
        ending_name = "unexpected text";
        send_frame(1'b0, 3'd0, OP_TEXT, 2, FORM_SHORT, 1'b0, 32'd0, 2, -1);
        send_frame(1'b1, 3'd0, OP_TEXT, 1, FORM_SHORT, 1'b0, 32'd0, 0, -1);
      end
      7: begin
        ending_name = "unexpected continuation";
        send_frame(1'b1, 3'd0, OP_CONT, 1, FORM_SHORT, 1'b0, 32'd0, 0, -1);
      end
      default: begin
        ending_name = "unknown opcode";
        odd_op = $urandom_range(1) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
        send_frame(1'b1, 3'd0, odd_op, 1, FORM_SHORT, 1'b0, 32'd0, 0, -1);
      end
    endcase
    repeat (12) push_byte(8'($urandom));
    wait_for_results();
  endtask

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_limit_settings();
    test_random_traffic(16, 78, 350);
    test_random_traffic(78, 16, 350);
    test_random_traffic(0, 0, 350);
    test_backpressure();
    test_stop_condition();

    $display("%0d bytes sent, %0d results checked, %0d mismatches",
             bytes_sent, results_seen, mismatch_count);
    $display("covered limits 0, 5, all ones and reset; stopped by %s", ending_name);
    if (mismatch_count == 0) begin
      $display("websocket_text_message_deframer: match");
    end else begin
      $display("websocket_text_message_deframer: mismatch");
    end
    $finish;
  end

endmodule
